// ===== rtl/core/periodic_poll_scheduler_unit_assert.svh =====
// Assertion macros used by the scheduler back end (pps_back).
// Each macro expects signals named clk and rst in the including scope.
`ifndef PERIODIC_POLL_SCHEDULER_UNIT_ASSERT_SVH
`define PERIODIC_POLL_SCHEDULER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Consequent checked in the cycle after the antecedent.
`define PPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

// ===== rtl/core/pps_pkg.sv =====
// Shared types and constants of the periodic poll scheduler.
// No dependencies; used by the front end, the back end and the top module.
package pps_pkg;

  localparam int MAX_ENTRIES_DEF = 32;
  localparam int MAX_GROUPS_DEF  = 16;
  localparam int PID_TYPES_DEF   = 8;

  typedef logic [2:0] op_t;
  localparam op_t OP_WR_ENTRY  = 3'd0;
  localparam op_t OP_WR_GROUP  = 3'd1;
  localparam op_t OP_RESTART   = 3'd2;
  localparam op_t OP_GROUP_RT  = 3'd3;
  localparam op_t OP_QUERY     = 3'd4;
  localparam op_t OP_REPORT    = 3'd5;
  localparam op_t OP_NOP       = 3'd7;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ENTRY_COUNT   = 3'd0;
  localparam cfg_idx_t CFG_GROUP_COUNT   = 3'd1;
  localparam cfg_idx_t CFG_TYPE_MASK     = 3'd2;
  localparam cfg_idx_t CFG_STAGGER       = 3'd3;
  localparam cfg_idx_t CFG_BACKOFF_STRK  = 3'd4;
  localparam cfg_idx_t CFG_BACKOFF_MULT  = 3'd5;

  localparam logic [23:0] PERIOD_ZERO_MS = 24'd1000;
  localparam logic [9:0]  MS_TO_US       = 10'd1000;
  localparam logic [15:0] STREAK_MAX     = 16'hFFFF;
  localparam logic [24:0] NO_OVERRIDE    = 25'h1FFFFFF;

  typedef struct packed {
    logic [5:0]  active_entries;
    logic [4:0]  group_count;
    logic [7:0]  type_mask;
    logic [19:0] stagger;
    logic [15:0] backoff_streak;
    logic [4:0]  backoff_mult;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [4:0]  idx;
    logic [61:0] now;
    logic [23:0] per;
    logic [24:0] ov;
    logic [3:0]  grp;
    logic [2:0]  typ;
    logic        pid;
    logic        en;
    logic        ok;
  } req_t;

  typedef struct packed {
    logic [23:0] period;
    logic [3:0]  grp;
    logic [2:0]  pid_type;
    logic        is_pid;
    logic        enabled;
  } entry_t;

  typedef struct packed {
    logic        found;
    logic [4:0]  entry;
    logic [62:0] due;
  } res_t;

endpackage

// ===== rtl/core/pps_front.sv =====
// Front end: accepts requests, classifies them and queues them for the engine.
// Depends on pps_pkg.
module pps_front #(
  parameter int MAX_ENTRIES = pps_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_GROUPS  = pps_pkg::MAX_GROUPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         req_type,
  input  logic [4:0]         index,
  input  logic [61:0]        now_us,
  input  logic [23:0]        req_period,
  input  logic signed [24:0] override_ms,
  input  logic [3:0]         group,
  input  logic [2:0]         pid_type,
  input  logic               is_pid,
  input  logic               enabled,
  input  logic               ok,
  output logic               q_valid,
  output pps_pkg::req_t      q_req,
  input  logic               q_pop
);
  import pps_pkg::*;

  req_t       cls;
  req_t       fifo_q [2];
  logic [1:0] count;
  logic       wp;
  logic       rp;
  logic       accept;
  logic       ent_ok;
  logic       grp_ok;

  assign ent_ok = 32'(index) < MAX_ENTRIES;
  assign grp_ok = 32'(index) < MAX_GROUPS;

  always_comb begin
    cls.idx = index;
    cls.now = now_us;
    cls.per = req_period;
    cls.ov  = override_ms;
    cls.grp = group;
    cls.typ = pid_type;
    cls.pid = is_pid;
    cls.en  = enabled;
    cls.ok  = ok;
    unique case (req_type)
      OP_WR_ENTRY: cls.op = ent_ok ? OP_WR_ENTRY : OP_NOP;
      OP_WR_GROUP: cls.op = grp_ok ? OP_WR_GROUP : OP_NOP;
      OP_RESTART:  cls.op = OP_RESTART;
      OP_GROUP_RT: cls.op = grp_ok ? OP_GROUP_RT : OP_NOP;
      OP_QUERY:    cls.op = OP_QUERY;
      OP_REPORT:   cls.op = ent_ok ? OP_REPORT : OP_NOP;
      default:     cls.op = OP_NOP;
    endcase
  end

  assign req_stall = count == 2'd2;
  assign accept    = req_valid && !req_stall;
  assign q_valid   = count != 2'd0;
  assign q_req     = fifo_q[rp];

  always_ff @(posedge clk) begin
    if (accept) begin
      fifo_q[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (accept) begin
        wp <= !wp;
      end
      if (q_pop) begin
        rp <= !rp;
      end
      count <= count + {1'b0, accept} - {1'b0, q_pop};
    end
  end

endmodule

// ===== rtl/core/pps_back.sv =====
// Back end: executes queued requests against the entry, group and slot stores.
// Depends on pps_pkg and periodic_poll_scheduler_unit_assert.svh.
`include "periodic_poll_scheduler_unit_assert.svh"
module pps_back #(
  parameter int MAX_ENTRIES = pps_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_GROUPS  = pps_pkg::MAX_GROUPS_DEF,
  parameter int PID_TYPES   = pps_pkg::PID_TYPES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  pps_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  pps_pkg::req_t q_req,
  output logic          q_pop,
  input  logic          res_free,
  output logic          res_load,
  output pps_pkg::res_t res
);
  import pps_pkg::*;

  localparam int EW        = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
  localparam int GW        = MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1;
  localparam int CW        = $clog2(MAX_ENTRIES + 1);
  localparam int NGW       = $clog2(MAX_GROUPS + 1);
  localparam int SWEEP_LEN = MAX_ENTRIES > MAX_GROUPS ? MAX_ENTRIES : MAX_GROUPS;
  localparam int SW        = $clog2(SWEEP_LEN + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SWEEP   = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_RPT_RD  = 3'd3;
  localparam logic [2:0] S_RPT_MUL = 3'd4;
  localparam logic [2:0] S_RPT_US  = 3'd5;
  localparam logic [2:0] S_RPT_WR  = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0] state;
  req_t       cur;

  entry_t      entry_mem [MAX_ENTRIES];
  logic [62:0] due_mem   [MAX_ENTRIES];
  logic [61:0] last_mem  [MAX_ENTRIES];
  logic [15:0] strk_mem  [MAX_ENTRIES];
  logic        slot_valid [MAX_ENTRIES];

  logic [23:0] grp_period  [MAX_GROUPS];
  logic        grp_default [MAX_GROUPS];
  logic        en_now      [MAX_GROUPS];
  logic [24:0] override    [MAX_GROUPS];

  logic [EW-1:0] rd_addr;
  entry_t        ent_q;
  logic [62:0]   due_q;
  logic [61:0]   last_q;
  logic [15:0]   strk_q;
  logic          sv_q;

  logic          slot_we;
  logic [EW-1:0] slot_waddr;
  logic [62:0]   slot_wdue;
  logic [61:0]   slot_wlast;
  logic [15:0]   slot_wstrk;

  logic [CW-1:0]  n_ent;
  logic [NGW-1:0] n_grp;
  logic [CW-1:0]  k;
  logic [SW-1:0]  sk;
  logic [62:0]    acc;
  logic           scan_v;
  logic [EW-1:0]  sidx;
  logic           have;
  logic [EW-1:0]  best_idx;
  logic [62:0]    best_due;
  logic [61:0]    best_last;

  logic [GW-1:0] g_s;
  logic          gval_s;
  logic          typ_ok;
  logic          en_s;
  logic [62:0]   d_s;
  logic [61:0]   l_s;
  logic [15:0]   st_s;
  logic          better;
  logic [24:0]   ovr;
  logic          has_ov;
  logic [15:0]   strk_new;
  logic [23:0]   p_sel;
  logic          bo;

  logic [23:0] p_reg;
  logic        bo_reg;
  logic [15:0] strk_reg;
  logic [28:0] pm_reg;
  logic [38:0] pus_reg;

  logic         sk_ent;
  logic         sk_grp;
  logic [GW-1:0] sk_g;

  assign n_ent = (32'(cfg.active_entries) > MAX_ENTRIES) ? CW'(MAX_ENTRIES)
                                                         : CW'(cfg.active_entries);
  assign n_grp = (32'(cfg.group_count) > MAX_GROUPS) ? NGW'(MAX_GROUPS) : NGW'(cfg.group_count);

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign res_load = (state == S_DONE) && res_free;

  assign rd_addr = (state == S_SCAN) ? EW'(k) : EW'(q_req.idx);

  always_ff @(posedge clk) begin
    ent_q  <= entry_mem[rd_addr];
    due_q  <= due_mem[rd_addr];
    last_q <= last_mem[rd_addr];
    strk_q <= strk_mem[rd_addr];
    if (q_pop && q_req.op == OP_WR_ENTRY) begin
      entry_mem[EW'(q_req.idx)] <= '{period: q_req.per, grp: q_req.grp,
                                     pid_type: q_req.typ, is_pid: q_req.pid,
                                     enabled: q_req.en};
    end
    if (slot_we) begin
      due_mem[slot_waddr]  <= slot_wdue;
      last_mem[slot_waddr] <= slot_wlast;
      strk_mem[slot_waddr] <= slot_wstrk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv_q <= 1'b0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        slot_valid[i] <= 1'b0;
      end
    end else begin
      sv_q <= slot_valid[rd_addr];
      if (slot_we) begin
        slot_valid[slot_waddr] <= 1'b1;
      end
    end
  end

  assign g_s    = GW'(ent_q.grp);
  assign gval_s = 32'(ent_q.grp) < 32'(n_grp);
  assign typ_ok = !ent_q.is_pid ||
                  (32'(ent_q.pid_type) < PID_TYPES && cfg.type_mask[ent_q.pid_type]);
  assign en_s   = ent_q.enabled && gval_s && en_now[g_s] && typ_ok;
  assign d_s    = sv_q ? due_q : '0;
  assign l_s    = sv_q ? last_q : '0;
  assign st_s   = sv_q ? strk_q : '0;
  assign better = !have || d_s < best_due || (d_s == best_due && l_s < best_last);

  assign ovr    = override[g_s];
  assign has_ov = !ovr[24];

  always_comb begin
    if (cur.ok) begin
      strk_new = '0;
    end else if (st_s < STREAK_MAX) begin
      strk_new = st_s + 16'd1;
    end else begin
      strk_new = st_s;
    end
    if (ent_q.period == '0) begin
      p_sel = gval_s ? (has_ov ? ovr[23:0] : grp_period[g_s]) : '0;
    end else begin
      p_sel = (gval_s && has_ov) ? ovr[23:0] : ent_q.period;
    end
    bo = strk_new >= cfg.backoff_streak;
    if (bo && p_sel == '0) begin
      p_sel = PERIOD_ZERO_MS;
    end
  end

  assign sk_ent = 32'(sk) < MAX_ENTRIES;
  assign sk_grp = 32'(sk) < MAX_GROUPS && 32'(sk) < 32'(n_grp);
  assign sk_g   = GW'(sk);

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = EW'(sk);
    slot_wdue  = (32'(sk) < 32'(n_ent)) ? acc : '0;
    slot_wlast = '0;
    slot_wstrk = '0;
    if (state == S_SWEEP) begin
      slot_we = sk_ent;
    end else if (state == S_RPT_WR) begin
      slot_we    = 1'b1;
      slot_waddr = EW'(cur.idx);
      slot_wdue  = 63'(cur.now) + 63'(pus_reg);
      slot_wlast = cur.now;
      slot_wstrk = strk_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_req.op == OP_WR_GROUP) begin
      grp_period[GW'(q_req.idx)]  <= q_req.per;
      grp_default[GW'(q_req.idx)] <= q_req.en;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < MAX_GROUPS; g++) begin
        en_now[g]   <= 1'b0;
        override[g] <= NO_OVERRIDE;
      end
    end else if (q_pop && q_req.op == OP_GROUP_RT) begin
      en_now[GW'(q_req.idx)]   <= q_req.en;
      override[GW'(q_req.idx)] <= q_req.ov[24] ? NO_OVERRIDE : q_req.ov;
    end else if (state == S_SWEEP && sk_grp) begin
      en_now[sk_g]   <= grp_default[sk_g];
      override[sk_g] <= NO_OVERRIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RPT_RD) begin
      p_reg    <= p_sel;
      bo_reg   <= bo;
      strk_reg <= strk_new;
    end
    pm_reg  <= bo_reg ? 29'(p_reg) * 29'(cfg.backoff_mult) : 29'(p_reg);
    pus_reg <= 39'(pm_reg) * 39'(MS_TO_US);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      scan_v <= 1'b0;
      have   <= 1'b0;
      k      <= '0;
      sk     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur       <= q_req;
            res.found <= 1'b0;
            res.entry <= '0;
            res.due   <= '0;
            k         <= '0;
            sk        <= '0;
            scan_v    <= 1'b0;
            have      <= 1'b0;
            acc       <= 63'(q_req.now);
            unique case (q_req.op)
              OP_RESTART: state <= S_SWEEP;
              OP_QUERY:   state <= S_SCAN;
              OP_REPORT:  state <= S_RPT_RD;
              default:    state <= S_DONE;
            endcase
          end
        end
        S_SWEEP: begin
          acc <= acc + 63'(cfg.stagger);
          sk  <= sk + SW'(1);
          if (32'(sk) == SWEEP_LEN - 1) begin
            state <= S_DONE;
          end
        end
        S_SCAN: begin
          if (k < n_ent) begin
            k      <= k + CW'(1);
            scan_v <= 1'b1;
            sidx   <= EW'(k);
          end else begin
            scan_v <= 1'b0;
          end
          if (scan_v && en_s && better) begin
            have      <= 1'b1;
            best_idx  <= sidx;
            best_due  <= d_s;
            best_last <= l_s;
          end
          if (k >= n_ent && !scan_v) begin
            res.found <= have;
            res.entry <= have ? 5'(best_idx) : '0;
            res.due   <= have ? best_due : '0;
            state     <= S_DONE;
          end
        end
        S_RPT_RD:  state <= S_RPT_MUL;
        S_RPT_MUL: state <= S_RPT_US;
        S_RPT_US:  state <= S_RPT_WR;
        S_RPT_WR:  state <= S_DONE;
        S_DONE: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PPS_ASSERT_NOW(a_scan_bound, state == S_SCAN, k <= n_ent)
  `PPS_ASSERT_NEXT(a_load_to_idle, res_load, state == S_IDLE)
  `PPS_ASSERT_NOW(a_report_order, state == S_RPT_WR, $past(state) == S_RPT_US)
  `PPS_ASSERT_NOW(a_sweep_bound, state == S_SWEEP, 32'(sk) < SWEEP_LEN)

endmodule

// ===== rtl/core/periodic_poll_scheduler_unit.sv =====
// One request is executed at a time; a query reads one slot per cycle from the
// slot memory port, so its rate is set by the entry count in use.
// Synchronous active-high reset restores the register defaults, slot times and
// group runtime state at once, with no clearing pass.
module periodic_poll_scheduler_unit #(
  parameter int MAX_ENTRIES = pps_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_GROUPS  = pps_pkg::MAX_GROUPS_DEF,
  parameter int PID_TYPES   = pps_pkg::PID_TYPES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [19:0]        wr_data,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         req_type,
  input  logic [4:0]         index,
  input  logic [61:0]        now_us,
  input  logic [23:0]        req_period,
  input  logic signed [24:0] override_ms,
  input  logic [3:0]         group,
  input  logic [2:0]         pid_type,
  input  logic               is_pid,
  input  logic               enabled,
  input  logic               ok,
  output logic               res_valid,
  input  logic               res_stall,
  output logic               found,
  output logic [4:0]         entry,
  output logic [62:0]        due_us
);
  import pps_pkg::*;

  cfg_t cfg;
  logic q_valid;
  req_t q_req;
  logic q_pop;
  logic res_free;
  logic res_load;
  res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_entries <= 6'd0;
      cfg.group_count    <= 5'd0;
      cfg.type_mask      <= 8'd255;
      cfg.stagger        <= 20'd20000;
      cfg.backoff_streak <= 16'd3;
      cfg.backoff_mult   <= 5'd4;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_ENTRY_COUNT:  cfg.active_entries <= wr_data[5:0];
        CFG_GROUP_COUNT:  cfg.group_count    <= wr_data[4:0];
        CFG_TYPE_MASK:    cfg.type_mask      <= wr_data[7:0];
        CFG_STAGGER:      cfg.stagger        <= wr_data;
        CFG_BACKOFF_STRK: cfg.backoff_streak <= wr_data[15:0];
        CFG_BACKOFF_MULT: cfg.backoff_mult   <= wr_data[4:0];
        default: ;
      endcase
    end
  end

  pps_front #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .MAX_GROUPS (MAX_GROUPS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .index      (index),
    .now_us     (now_us),
    .req_period (req_period),
    .override_ms(override_ms),
    .group      (group),
    .pid_type   (pid_type),
    .is_pid     (is_pid),
    .enabled    (enabled),
    .ok         (ok),
    .q_valid    (q_valid),
    .q_req      (q_req),
    .q_pop      (q_pop)
  );

  pps_back #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .MAX_GROUPS (MAX_GROUPS),
    .PID_TYPES  (PID_TYPES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_req   (q_req),
    .q_pop   (q_pop),
    .res_free(res_free),
    .res_load(res_load),
    .res     (res)
  );

  assign res_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      found  <= res.found;
      entry  <= res.entry;
      due_us <= res.due;
    end
  end

endmodule
